// ===== rtl/key_matrix_hid_report_builder_defines.svh =====
// assertion macros for the key matrix report builder
`ifndef KEY_MATRIX_HID_REPORT_BUILDER_DEFINES_SVH
`define KEY_MATRIX_HID_REPORT_BUILDER_DEFINES_SVH

// condition must hold in the same cycle
`define KMHID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the next cycle
`define KMHID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/kmhid_pkg.sv =====
// shared types and constants for the key matrix report builder
package kmhid_pkg;

  localparam int          SLOT_FIELDS = 6;
  localparam int          CODE_W      = 8;
  localparam int          COUNT_W     = 3;
  localparam logic [7:0]  KEY_NONE    = 8'h00;
  localparam logic [7:0]  MOD_FIRST   = 8'hE0;
  localparam logic [7:0]  MOD_LAST    = 8'hE7;
  localparam logic [7:0]  MOD_MASK    = 8'b0000_1111;
  localparam logic [7:0]  MOD_ONE     = 8'h01;

  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef code_t              slots_t [SLOT_FIELDS];

  // control from the sequencer to the accumulator
  typedef struct packed {
    logic add;
    logic clear;
  } acc_ctrl_t;

endpackage

// ===== rtl/kmhid_acc.sv =====
// report accumulator: slot fill, modifier bits and key count
module kmhid_acc #(
  parameter int ROLLOVER = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  kmhid_pkg::acc_ctrl_t ctrl,
  input  kmhid_pkg::code_t    code,
  output kmhid_pkg::code_t    modifier,
  output kmhid_pkg::slots_t   slots,
  output kmhid_pkg::count_t   count
);
  import kmhid_pkg::*;

  code_t  modifier_r, modifier_nxt;
  slots_t slots_r, slots_nxt;
  count_t count_r, count_nxt;
  logic   full;
  logic   take;
  logic   is_mod;

  // slot availability and modifier range check
  assign full   = (32'(count_r) >= ROLLOVER) || (32'(count_r) >= SLOT_FIELDS);
  assign take   = ctrl.add && (code != KEY_NONE) && !full;
  assign is_mod = (code >= MOD_FIRST) && (code <= MOD_LAST);

  // next accumulation, clear wins
  always_comb begin
    modifier_nxt = modifier_r;
    slots_nxt    = slots_r;
    count_nxt    = count_r;
    if (ctrl.clear) begin
      modifier_nxt = KEY_NONE;
      for (int i = 0; i < SLOT_FIELDS; i++) begin
        slots_nxt[i] = KEY_NONE;
      end
      count_nxt = '0;
    end else if (take) begin
      if (is_mod) begin
        modifier_nxt = modifier_r | (MOD_ONE << (code & MOD_MASK));
      end
      slots_nxt[count_r] = code;
      count_nxt          = count_r + count_t'(1);
    end
  end

  // accumulator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modifier_r <= KEY_NONE;
      for (int i = 0; i < SLOT_FIELDS; i++) begin
        slots_r[i] <= KEY_NONE;
      end
      count_r <= '0;
    end else begin
      modifier_r <= modifier_nxt;
      slots_r    <= slots_nxt;
      count_r    <= count_nxt;
    end
  end

  assign modifier = modifier_r;
  assign slots    = slots_r;
  assign count    = count_r;

endmodule

// ===== rtl/key_matrix_hid_report_builder.sv =====
// top level: key map store, column walk sequencer and report output register
// load item: accepted while idle, in_tready stays high
// row sample: walks min(COLUMNS,4) columns in S_WALK, then S_TAIL, before ready; one key map read per cycle
// last row sample: then S_EMIT loads the report, held while out_tvalid waits
//   on out_tready; the result item is valid the cycle after, the next item may enter
// reset: synchronous, active low; clears sequencer state, accumulator and out_tvalid, not the map
`include "key_matrix_hid_report_builder_defines.svh"

module key_matrix_hid_report_builder #(
  parameter int ROWS     = 4,
  parameter int COLUMNS  = 4,
  parameter int ROLLOVER = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // row_index, column_index, map_code, column_bits
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata  // report_modifier, slot_zero..slot_five, key_count
);
  import kmhid_pkg::*;

  localparam int COL_BITS  = 4;
  localparam int WALK      = (COLUMNS < COL_BITS) ? COLUMNS : COL_BITS;
  localparam int CW        = $clog2(WALK + 1);
  localparam int MAP_DEPTH = ROWS * COLUMNS;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          row_r, row_nxt;
  logic [COL_BITS-1:0] bits_r, bits_nxt;
  logic [CW-1:0]       col_r, col_nxt;
  logic                hit_r, hit_nxt;
  code_t               rd_r;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [63:0]         out_tdata_r, out_tdata_nxt;

  code_t               map_mem [MAP_DEPTH];

  logic                in_fire;
  logic [1:0]          in_row;
  logic [1:0]          in_col;
  code_t               in_code;
  logic [COL_BITS-1:0] in_bits;
  logic                row_ok;
  logic                col_ok;
  logic                load_we;
  logic [MAP_AW-1:0]   wr_addr;
  logic [MAP_AW-1:0]   rd_addr;
  logic                emit;
  logic                out_free;
  acc_ctrl_t           acc_ctrl;
  code_t               acc_modifier;
  slots_t              acc_slots;
  count_t              acc_count;

  // input unpacking
  assign in_row  = in_tdata[1:0];
  assign in_col  = in_tdata[3:2];
  assign in_code = in_tdata[11:4];
  assign in_bits = in_tdata[15:12];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign row_ok    = (32'(in_row) < ROWS);
  assign col_ok    = (32'(in_col) < COLUMNS);
  assign load_we   = in_fire && (in_tuser == ACT_LOAD) && row_ok && col_ok;

  // key map addressing
  assign wr_addr = MAP_AW'(32'(in_row) * COLUMNS + 32'(in_col));
  assign rd_addr = MAP_AW'(32'(row_r) * COLUMNS + 32'(col_r));

  // key map store, registered read
  always_ff @(posedge clk) begin
    if (load_we) begin
      map_mem[wr_addr] <= in_code;
    end
    rd_r <= map_mem[rd_addr];
  end

  assign out_free = !out_tvalid_r || out_tready;
  assign emit     = (state_r == S_EMIT) && out_free;

  // accumulator control
  assign acc_ctrl.add   = hit_r;
  assign acc_ctrl.clear = emit;

  kmhid_acc #(
    .ROLLOVER (ROLLOVER)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (acc_ctrl),
    .code     (rd_r),
    .modifier (acc_modifier),
    .slots    (acc_slots),
    .count    (acc_count)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    row_nxt   = row_r;
    bits_nxt  = bits_r;
    col_nxt   = col_r;
    hit_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_fire && (in_tuser == ACT_SAMPLE) && row_ok) begin
          row_nxt   = in_row;
          bits_nxt  = in_bits;
          col_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // read entry of col_r now, its pressed flag lines up with the read data
        hit_nxt  = bits_r[0];
        bits_nxt = bits_r >> 1;
        col_nxt  = col_r + CW'(1);
        if (32'(col_r) == WALK - 1) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        if (32'(row_r) == ROWS - 1) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (emit) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {5'b0, acc_count, acc_slots[5], acc_slots[4], acc_slots[3],
                        acc_slots[2], acc_slots[1], acc_slots[0], acc_modifier};
    end
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hit_r        <= hit_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    row_r       <= row_nxt;
    bits_r      <= bits_nxt;
    col_r       <= col_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // checks
  `KMHID_ASSERT_NOW(a_acc_count_max, 1'b1, 32'(acc_count) <= ROLLOVER, "key count above rollover")
  `KMHID_ASSERT_NEXT(a_emit_clears, emit, (acc_count == '0) && out_tvalid_r, "emit not done")
  `KMHID_ASSERT_NOW(a_add_walk, hit_r, (state_r == S_WALK) || (state_r == S_TAIL), "stray add")

endmodule

// ===== dv/key_matrix_hid_report_builder_test.sv =====
// testbench for the key matrix six-key-rollover report builder
`timescale 1ns / 1ps

module key_matrix_hid_report_builder_test;
  import kmhid_pkg::*;

  localparam int   ROWS      = 4;
  localparam int   COLUMNS   = 4;
  localparam int   ROLLOVER  = 6;
  localparam int   MAP_DEPTH = ROWS * COLUMNS;
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_SCAN  = 1'b1;
  localparam int   CYCLE_LIMIT  = 1000000;
  localparam int   RANDOM_ITEMS = 1030;

  // report predictor and in-order result check
  class report_scoreboard;
    code_t       key_map [MAP_DEPTH];
    code_t       acc_mod;
    code_t       acc_slots [SLOT_FIELDS];
    count_t      acc_count;
    logic [63:0] pending_reports [$];
    int          failures;
    int          shown;

    function new();
      acc_mod   = KEY_NONE;
      acc_count = '0;
      foreach (acc_slots[i]) acc_slots[i] = KEY_NONE;
      foreach (key_map[i]) key_map[i] = KEY_NONE;
      failures = 0;
      shown    = 0;
    endfunction

    // field f of a packed report: 0 modifier, 1..6 slots, 7 count, 8 padding
    function logic [7:0] field_of(logic [63:0] w, int f);
      if (f < 7) return w[f*8 +: 8];
      if (f == 7) return {5'b0, w[58:56]};
      return {3'b0, w[63:59]};
    endfunction

    function void note_input(logic action, logic [1:0] row, logic [1:0] col,
                             code_t code, logic [3:0] bits);
      code_t       k;
      logic [63:0] rep;
      if (action == ACT_LOAD) begin
        key_map[row * COLUMNS + col] = code;
        return;
      end
      // walk the pressed columns in ascending order
      for (int c = 0; c < COLUMNS; c++) begin
        if (bits[c]) begin
          k = key_map[row * COLUMNS + c];
          if (k != KEY_NONE && acc_count < ROLLOVER) begin
            if (k >= MOD_FIRST && k <= MOD_LAST)
              acc_mod = acc_mod | (MOD_ONE << (k & MOD_MASK));
            acc_slots[acc_count] = k;
            acc_count = acc_count + 1'b1;
          end
        end
      end
      if (row != ROWS - 1) return;
      // last row: emit and clear
      rep = '0;
      rep[7:0] = acc_mod;
      for (int j = 0; j < SLOT_FIELDS; j++) rep[8 + j*8 +: 8] = acc_slots[j];
      rep[58:56] = acc_count;
      pending_reports.push_back(rep);
      acc_mod   = KEY_NONE;
      acc_count = '0;
      foreach (acc_slots[i]) acc_slots[i] = KEY_NONE;
    endfunction

    function void flag(string msg);
      failures++;
      if (shown < 10) begin
        shown++;
        $display("mismatch: %s", msg);
      end
    endfunction

    function void check_report(logic [63:0] actual);
      string       names [9];
      logic [63:0] want;
      names = '{"report_modifier", "slot_zero", "slot_one", "slot_two", "slot_three",
                "slot_four", "slot_five", "key_count", "padding"};
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected report %h", actual));
        return;
      end
      want = pending_reports.pop_front();
      for (int f = 0; f < 9; f++) begin
        if (field_of(actual, f) !== field_of(want, f))
          flag($sformatf("%s expected %h got %h (report expected %h got %h)",
                         names[f], field_of(want, f), field_of(actual, f), want, actual));
      end
    endfunction

    function int outstanding();
      return pending_reports.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;

  report_scoreboard board;
  int   cycles;
  int   items_sent;
  bit   send_busy_mode;
  bit   sink_busy_mode;
  int   stall_left;
  bit   written [MAP_DEPTH];

  key_matrix_hid_report_builder #(
    .ROWS(ROWS), .COLUMNS(COLUMNS), .ROLLOVER(ROLLOVER)
  ) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run-length watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result sink with random stalls
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (sink_busy_mode) begin
        case ($urandom_range(0, 99)) inside
          [0:24]:  stall_left <= $urandom_range(1, 3);
          [25:29]: stall_left <= $urandom_range(4, 12);
          [30:31]: stall_left <= $urandom_range(20, 60);
          default: stall_left <= 0;
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_report(out_tdata);
  end

  function automatic int pick_gap();
    if (!send_busy_mode) return 0;
    case ($urandom_range(0, 99)) inside
      [0:59]:  return 0;
      [60:89]: return $urandom_range(1, 3);
      [90:97]: return $urandom_range(4, 10);
      default: return $urandom_range(20, 60);
    endcase
  endfunction

  // keycodes weighted toward modifiers, empty entries and range edges
  function automatic code_t pick_code();
    case ($urandom_range(0, 99)) inside
      [0:14]:  return KEY_NONE;
      [15:39]: return MOD_FIRST + 8'($urandom_range(0, 7));
      [40:47]: begin
        case ($urandom_range(0, 3))
          0: return 8'hDF;
          1: return 8'hE8;
          2: return 8'hFF;
          default: return 8'h01;
        endcase
      end
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one item through the input channel, noted at acceptance
  task automatic send_item(logic action, logic [1:0] row, logic [1:0] col,
                           code_t code, logic [3:0] bits);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = action;
    in_tdata  = {bits, code, col, row};
    do @(posedge clk); while (!in_tready);
    board.note_input(action, row, col, code, bits);
    if (action == ACT_LOAD) written[row * COLUMNS + col] = 1'b1;
    items_sent++;
  endtask

  // sample with only loaded entries allowed to be pressed
  task automatic send_sample(logic [1:0] row, logic [3:0] bits);
    logic [3:0] allowed;
    for (int c = 0; c < COLUMNS; c++) allowed[c] = written[row * COLUMNS + c];
    send_item(ACT_SCAN, row, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
              bits & allowed);
  endtask

  // stop sending and wait for every expected report
  task automatic drain_reports();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    code_t      seed_map [MAP_DEPTH];
    int         pick;
    int         n;
    logic [3:0] bits;

    board          = new();
    cycles         = 0;
    items_sent     = 0;
    send_busy_mode = 1'b0;
    sink_busy_mode = 1'b0;
    stall_left     = 0;
    foreach (written[i]) written[i] = 1'b0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = ACT_LOAD;
    in_tdata   = '0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: fill the whole map with edge codes
    seed_map = '{8'hE0, 8'hE7, 8'h04, 8'h00,
                 8'hFF, 8'hDF, 8'hE8, 8'h01,
                 8'hE3, 8'h1E, 8'h2C, 8'hE5,
                 8'h80, 8'h7F, 8'h00, 8'hE1};
    for (int i = 0; i < MAP_DEPTH; i++)
      send_item(ACT_LOAD, 2'(i / COLUMNS), 2'(i % COLUMNS), seed_map[i], 4'($urandom));
    // all keys pressed overflows the report
    for (int r = 0; r < ROWS; r++) send_sample(2'(r), 4'b1111);
    // empty report
    send_sample(2'(ROWS - 1), 4'b0000);
    // last row alone
    send_sample(2'(ROWS - 1), 4'b1111);
    // out of order and repeated rows
    send_sample(2'd2, 4'b1010);
    send_sample(2'd1, 4'b0101);
    send_sample(2'd0, 4'b0011);
    send_sample(2'd0, 4'b0011);
    send_sample(2'(ROWS - 1), 4'b0010);
    drain_reports();

    // random: mostly full scans, some reloads and stray rows
    send_busy_mode = 1'b1;
    sink_busy_mode = 1'b1;
    while (items_sent < MAP_DEPTH + 11 + RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        send_busy_mode = $urandom_range(0, 3) != 0;
        sink_busy_mode = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 29) == 0) drain_reports();
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        n = $urandom_range(1, 4);
        repeat (n)
          send_item(ACT_LOAD, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                    pick_code(), 4'($urandom));
      end else if (pick < 82) begin
        for (int r = 0; r < ROWS; r++) begin
          bits = ($urandom_range(0, 3) == 0) ? 4'b1111 : 4'($urandom);
          send_sample(2'(r), bits);
        end
      end else begin
        n = $urandom_range(1, 5);
        repeat (n) send_sample(2'($urandom_range(0, 3)), 4'($urandom));
      end
    end
    @(negedge clk);
    in_tvalid = 1'b0;

    // let the block finish and the results drain
    drain_reports();
    repeat (20) @(posedge clk);
    if (board.outstanding() != 0) board.flag("reports left over at end");
    if (board.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/kmhid_pkg.sv
rtl/kmhid_acc.sv
rtl/key_matrix_hid_report_builder.sv
dv/key_matrix_hid_report_builder_test.sv
